// File: rtl/core/pew_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types for the Prewitt edge magnitude block.
// No dependencies.
package pew_pkg;

    localparam int PIX_W         = 8;
    localparam int SUM_W         = 10;
    localparam int ROW_W         = 12;
    localparam int COL_OUT_W     = 10;
    localparam int FW_W          = 11;
    localparam int FH_W          = 12;
    localparam int CFG_W         = 12;
    localparam int CFG_IDX_W     = 2;
    localparam int DEF_MAX_WIDTH = 1024;
    localparam int RESET_WIDTH   = 640;
    localparam int RESET_HEIGHT  = 480;
    localparam int MIN_DIM       = 3;
    localparam int PIX_MAX       = 255;
    localparam int WIN_CELLS     = 2;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

    // one window column, top to bottom
    typedef struct packed {
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] bot;
    } column_t;

endpackage

// File: rtl/core/prewitt_edge_magnitude_top.sv
`timescale 1ns / 1ps
// Prewitt 3x3 edge magnitude over a raster pixel stream.
// Depends on pew_pkg, pew_line_store, pew_col_cell, pew_kernel.
//
// Takes one pixel per clock and gives one result per interior pixel, via stage
// 1 and the output register, after the pixel that completes its 3x3 window;
// border pixels (first two rows and columns) give no result. Both line stores
// share one memory with one read and one write port: the read for a column is
// issued when the pixel is accepted and the write-back happens as the item
// moves to the output register, so the stream runs at a full item per cycle
// while out_stall is low. Frame width is clamped to 3..MAX_WIDTH and height
// to at least 3. Any write to frame_width or frame_height restarts the frame
// at row 0, column 0; line store contents are kept and have no reset.
module prewitt_edge_magnitude_top #(
    parameter int MAX_WIDTH = pew_pkg::DEF_MAX_WIDTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [pew_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pew_pkg::CFG_W-1:0]       cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [pew_pkg::PIX_W-1:0]       pixel,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [pew_pkg::PIX_W-1:0]       edge_res,
    output logic [pew_pkg::PIX_W-1:0]       vertical_part,
    output logic [pew_pkg::PIX_W-1:0]       horizontal_part,
    output logic [pew_pkg::ROW_W-1:0]       out_row,
    output logic [pew_pkg::COL_OUT_W-1:0]   out_col,
    output logic                            frame_last
);

    localparam int PW    = pew_pkg::PIX_W;
    localparam int RW    = pew_pkg::ROW_W;
    localparam int COW   = pew_pkg::COL_OUT_W;
    localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WUW_A = $clog2(MAX_WIDTH + 1);
    localparam int WUW   = (WUW_A > pew_pkg::FW_W) ? WUW_A : pew_pkg::FW_W;
    localparam int CXW   = (CW > COW) ? CW : COW;
    localparam int NC    = pew_pkg::WIN_CELLS;

    // configuration
    logic [pew_pkg::FW_W-1:0] frame_width_reg;
    logic [pew_pkg::FW_W-1:0] frame_width_next;
    logic [pew_pkg::FH_W-1:0] frame_height_reg;
    logic [pew_pkg::FH_W-1:0] frame_height_next;
    logic                     cfg_hit;

    logic [WUW-1:0] fw_ext;
    logic [WUW-1:0] w_use;
    logic [CW-1:0]  col_last;
    logic [RW-1:0]  h_use;
    logic [RW-1:0]  row_last;

    // raster position
    logic [CW-1:0] col_reg;
    logic [CW-1:0] col_next;
    logic [RW-1:0] row_reg;
    logic [RW-1:0] row_next;

    // handshake
    logic out_free;
    logic adv;
    logic in_fire;

    // item in flight, waiting for line store read data
    logic           s1_valid_reg;
    logic           s1_valid_next;
    logic [PW-1:0]  s1_pixel_reg;
    logic [CW-1:0]  s1_addr_reg;
    logic           s1_interior_reg;
    logic           s1_last_reg;
    logic [RW-1:0]  s1_row_reg;
    logic [COW-1:0] s1_col_reg;
    logic [CXW-1:0] col_minus;

    // line stores: [2*PW-1:PW] newer line, [PW-1:0] older line
    logic [2*PW-1:0] ls_rd_data;
    logic [2*PW-1:0] ls_wr_data;

    pew_pkg::column_t cols [NC+1];

    logic [PW-1:0] k_edge;
    logic [PW-1:0] k_vert;
    logic [PW-1:0] k_horz;

    // output register
    logic           out_valid_reg;
    logic           out_valid_next;
    logic [PW-1:0]  edge_reg;
    logic [PW-1:0]  vert_reg;
    logic [PW-1:0]  horz_reg;
    logic [RW-1:0]  orow_reg;
    logic [COW-1:0] ocol_reg;
    logic           olast_reg;

    assign cfg_hit = cfg_we && ((cfg_index == pew_pkg::REG_FRAME_WIDTH) ||
                                (cfg_index == pew_pkg::REG_FRAME_HEIGHT));

    always_comb
    begin
        frame_width_next  = frame_width_reg;
        frame_height_next = frame_height_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                pew_pkg::REG_FRAME_WIDTH:
                begin
                    frame_width_next = cfg_data[pew_pkg::FW_W-1:0];
                end
                pew_pkg::REG_FRAME_HEIGHT:
                begin
                    frame_height_next = cfg_data[pew_pkg::FH_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= pew_pkg::FW_W'(pew_pkg::RESET_WIDTH);
            frame_height_reg <= pew_pkg::FH_W'(pew_pkg::RESET_HEIGHT);
        end
        else
        begin
            frame_width_reg  <= frame_width_next;
            frame_height_reg <= frame_height_next;
        end
    end

    always_comb
    begin
        fw_ext = WUW'(frame_width_reg);
        if (fw_ext < WUW'(pew_pkg::MIN_DIM))
        begin
            w_use = WUW'(pew_pkg::MIN_DIM);
        end
        else if (fw_ext > WUW'(MAX_WIDTH))
        begin
            w_use = WUW'(MAX_WIDTH);
        end
        else
        begin
            w_use = fw_ext;
        end
        col_last = CW'(w_use - WUW'(1));

        h_use    = (frame_height_reg < RW'(pew_pkg::MIN_DIM)) ? RW'(pew_pkg::MIN_DIM)
                                                              : frame_height_reg;
        row_last = h_use - RW'(1);
    end

    assign out_free = !out_valid_reg || !out_stall;
    assign adv      = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;
    assign in_fire  = in_valid && !in_stall;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (cfg_hit)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (in_fire)
        begin
            if (col_reg == col_last)
            begin
                col_next = '0;
                row_next = (row_reg == row_last) ? '0 : row_reg + RW'(1);
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    always_comb
    begin
        if (in_fire)
        begin
            s1_valid_next = 1'b1;
        end
        else if (adv)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    assign col_minus = CXW'(col_reg) - CXW'(1);

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_pixel_reg    <= pixel;
            s1_addr_reg     <= col_reg;
            s1_interior_reg <= (row_reg >= RW'(2)) && (col_reg >= CW'(2));
            s1_last_reg     <= (row_reg == row_last) && (col_reg == col_last);
            s1_row_reg      <= row_reg - RW'(1);
            s1_col_reg      <= col_minus[COW-1:0];
        end
    end

    // read at accept, write back the shifted column as the item leaves stage 1
    assign ls_wr_data = {s1_pixel_reg, ls_rd_data[2*PW-1:PW]};

    pew_line_store #(
        .DEPTH  (MAX_WIDTH),
        .DATA_W (2 * PW),
        .ADDR_W (CW)
    ) u_line_store (
        .clk     (clk),
        .rd_en   (in_fire),
        .rd_addr (col_reg),
        .rd_data (ls_rd_data),
        .wr_en   (adv),
        .wr_addr (s1_addr_reg),
        .wr_data (ls_wr_data)
    );

    // cols[NC] is the incoming column; cells hold the two to its left
    always_comb
    begin
        cols[NC].top = ls_rd_data[PW-1:0];
        cols[NC].mid = ls_rd_data[2*PW-1:PW];
        cols[NC].bot = s1_pixel_reg;
    end

    for (genvar k = 0; k < NC; k++)
    begin : g_cells
        pew_col_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift_en (adv),
            .col_in   (cols[k+1]),
            .col_out  (cols[k])
        );
    end

    pew_kernel u_kernel (
        .left_col        (cols[0]),
        .center_col      (cols[1]),
        .right_col       (cols[2]),
        .edge_res        (k_edge),
        .vertical_part   (k_vert),
        .horizontal_part (k_horz)
    );

    always_comb
    begin
        if (adv)
        begin
            out_valid_next = s1_interior_reg;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && s1_interior_reg)
        begin
            edge_reg  <= k_edge;
            vert_reg  <= k_vert;
            horz_reg  <= k_horz;
            orow_reg  <= s1_row_reg;
            ocol_reg  <= s1_col_reg;
            olast_reg <= s1_last_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign edge_res        = edge_reg;
    assign vertical_part   = vert_reg;
    assign horizontal_part = horz_reg;
    assign out_row         = orow_reg;
    assign out_col         = ocol_reg;
    assign frame_last      = olast_reg;

endmodule

// File: rtl/core/pew_line_store.sv
`timescale 1ns / 1ps
// Line store: one write port, one read port with registered read data.
// Depends on nothing but its parameters.
module pew_line_store #(
    parameter int DEPTH  = 1024,
    parameter int DATA_W = 16,
    parameter int ADDR_W = 10
) (
    input  logic              clk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data
);

    logic [DATA_W-1:0] store_reg [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= store_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/core/pew_col_cell.sv
`timescale 1ns / 1ps
// Window cell: holds one 3-pixel column and hands it on when the window shifts.
// Depends on pew_pkg.
module pew_col_cell (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             shift_en,
    input  pew_pkg::column_t col_in,
    output pew_pkg::column_t col_out
);

    pew_pkg::column_t col_reg;
    pew_pkg::column_t col_next;

    always_comb
    begin
        col_next = shift_en ? col_in : col_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
        end
    end

    assign col_out = col_reg;

endmodule

// File: rtl/core/pew_kernel.sv
`timescale 1ns / 1ps
// Prewitt kernel: row and column sums, absolute differences, saturation.
// Depends on pew_pkg.
module pew_kernel (
    input  pew_pkg::column_t              left_col,
    input  pew_pkg::column_t              center_col,
    input  pew_pkg::column_t              right_col,
    output logic [pew_pkg::PIX_W-1:0]     edge_res,
    output logic [pew_pkg::PIX_W-1:0]     vertical_part,
    output logic [pew_pkg::PIX_W-1:0]     horizontal_part
);

    localparam int SW = pew_pkg::SUM_W;
    localparam int DW = pew_pkg::SUM_W + 1;
    localparam int PW = pew_pkg::PIX_W;

    logic [SW-1:0] top_sum;
    logic [SW-1:0] bot_sum;
    logic [SW-1:0] left_sum;
    logic [SW-1:0] right_sum;
    logic [DW-1:0] v_diff;
    logic [DW-1:0] h_diff;
    logic [DW-1:0] v_abs;
    logic [DW-1:0] h_abs;
    logic [PW-1:0] v_sat;
    logic [PW-1:0] h_sat;
    logic [PW:0]   e_sum;

    always_comb
    begin
        top_sum   = SW'(left_col.top) + SW'(center_col.top) + SW'(right_col.top);
        bot_sum   = SW'(left_col.bot) + SW'(center_col.bot) + SW'(right_col.bot);
        left_sum  = SW'(left_col.top) + SW'(left_col.mid) + SW'(left_col.bot);
        right_sum = SW'(right_col.top) + SW'(right_col.mid) + SW'(right_col.bot);

        v_diff = DW'(bot_sum) - DW'(top_sum);
        h_diff = DW'(right_sum) - DW'(left_sum);
        v_abs  = v_diff[DW-1] ? (DW'(0) - v_diff) : v_diff;
        h_abs  = h_diff[DW-1] ? (DW'(0) - h_diff) : h_diff;

        v_sat = (v_abs > DW'(pew_pkg::PIX_MAX)) ? PW'(pew_pkg::PIX_MAX) : v_abs[PW-1:0];
        h_sat = (h_abs > DW'(pew_pkg::PIX_MAX)) ? PW'(pew_pkg::PIX_MAX) : h_abs[PW-1:0];
        e_sum = {1'b0, v_sat} + {1'b0, h_sat};
    end

    assign vertical_part   = v_sat;
    assign horizontal_part = h_sat;
    assign edge_res        = e_sum[PW] ? PW'(pew_pkg::PIX_MAX) : e_sum[PW-1:0];

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for prewitt_edge_magnitude_top: streams pixel frames
// through the block and checks every edge item against an in-bench predictor.
// Depends on pew_pkg and the prewitt_edge_magnitude_top RTL.
module testbench;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_QUOTA  = 115;

    // register slots with no register behind them
    localparam logic [pew_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [pew_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    // pixel content styles
    localparam int MODE_NOISE    = 0;
    localparam int MODE_EXTREMES = 1;
    localparam int MODE_SMOOTH   = 2;

    typedef struct packed {
        logic [pew_pkg::PIX_W-1:0]     mag;
        logic [pew_pkg::PIX_W-1:0]     vert;
        logic [pew_pkg::PIX_W-1:0]     horiz;
        logic [pew_pkg::ROW_W-1:0]     row;
        logic [pew_pkg::COL_OUT_W-1:0] col;
        logic                          last;
    } edge_item_t;

    logic                          clk;
    logic                          rst_n     = 1'b0;
    logic                          cfg_we    = 1'b0;
    logic [pew_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [pew_pkg::CFG_W-1:0]     cfg_data  = '0;
    logic                          in_valid  = 1'b0;
    logic                          in_stall;
    logic [pew_pkg::PIX_W-1:0]     pixel     = '0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    logic [pew_pkg::PIX_W-1:0]     edge_res;
    logic [pew_pkg::PIX_W-1:0]     vertical_part;
    logic [pew_pkg::PIX_W-1:0]     horizontal_part;
    logic [pew_pkg::ROW_W-1:0]     out_row;
    logic [pew_pkg::COL_OUT_W-1:0] out_col;
    logic                          frame_last;

    prewitt_edge_magnitude_top dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .pixel           (pixel),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .edge_res        (edge_res),
        .vertical_part   (vertical_part),
        .horizontal_part (horizontal_part),
        .out_row         (out_row),
        .out_col         (out_col),
        .frame_last      (frame_last)
    );

    // predictor state
    bit [pew_pkg::PIX_W-1:0] older_row [pew_pkg::DEF_MAX_WIDTH];
    bit [pew_pkg::PIX_W-1:0] newer_row [pew_pkg::DEF_MAX_WIDTH];
    bit [pew_pkg::PIX_W-1:0] win [6];  // [k*3+v]: k=0 two columns left, v=0 top
    int                      col_pos;
    int                      row_pos;
    bit [pew_pkg::FW_W-1:0]  width_reg  = pew_pkg::FW_W'(pew_pkg::RESET_WIDTH);
    bit [pew_pkg::FH_W-1:0]  height_reg = pew_pkg::FH_W'(pew_pkg::RESET_HEIGHT);

    edge_item_t pending_edges [$];
    edge_item_t want_item;
    int         idle_pct;
    int         stall_pct;
    int         errors;
    int         cycle_count;
    int         pixels_sent;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("prewitt_edge_magnitude_top: mismatch");
            $finish;
        end
    end

    always @(negedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    function automatic int active_width();
        int w;
        w = int'(width_reg);
        if (w < pew_pkg::MIN_DIM)
            w = pew_pkg::MIN_DIM;
        if (w > pew_pkg::DEF_MAX_WIDTH)
            w = pew_pkg::DEF_MAX_WIDTH;
        return w;
    endfunction

    function automatic int active_height();
        return (int'(height_reg) < pew_pkg::MIN_DIM) ? pew_pkg::MIN_DIM : int'(height_reg);
    endfunction

    function automatic bit [pew_pkg::PIX_W-1:0] sat8(int d);
        int a;
        a = (d < 0) ? -d : d;
        if (a > pew_pkg::PIX_MAX)
            a = pew_pkg::PIX_MAX;
        return a[pew_pkg::PIX_W-1:0];
    endfunction

    // one pixel through the window; queues the edge item it completes, if any
    function automatic void predict_edge(bit [pew_pkg::PIX_W-1:0] p);
        int                      w;
        int                      h;
        int                      c;
        int                      r;
        int                      top_sum;
        int                      bot_sum;
        int                      left_sum;
        int                      right_sum;
        bit [pew_pkg::PIX_W-1:0] top;
        bit [pew_pkg::PIX_W-1:0] mid;
        edge_item_t              item;
        w = active_width();
        h = active_height();
        c = col_pos;
        r = row_pos;
        if (c >= w)
            c = w - 1;
        top = older_row[c];
        mid = newer_row[c];
        if (r >= 2 && c >= 2)
        begin
            top_sum   = int'(win[0]) + int'(win[3]) + int'(top);
            bot_sum   = int'(win[2]) + int'(win[5]) + int'(p);
            left_sum  = int'(win[0]) + int'(win[1]) + int'(win[2]);
            right_sum = int'(top) + int'(mid) + int'(p);
            item.vert  = sat8(bot_sum - top_sum);
            item.horiz = sat8(right_sum - left_sum);
            item.mag   = sat8(int'(item.vert) + int'(item.horiz));
            item.row   = pew_pkg::ROW_W'(r - 1);
            item.col   = pew_pkg::COL_OUT_W'(c - 1);
            item.last  = (r == h - 1) && (c == w - 1);
            pending_edges.push_back(item);
        end
        win[0] = win[3];
        win[1] = win[4];
        win[2] = win[5];
        win[3] = top;
        win[4] = mid;
        win[5] = p;
        older_row[c] = mid;
        newer_row[c] = p;
        c++;
        if (c >= w)
        begin
            c = 0;
            r++;
            if (r >= h)
                r = 0;
        end
        col_pos = c;
        row_pos = r;
    endfunction

    function automatic void check_field(string name, logic [11:0] want, logic [11:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && !out_stall)
        begin
            if (pending_edges.size() == 0)
            begin
                errors++;
                $display("%0t: edge item expected none, got row %0d col %0d",
                         $time, out_row, out_col);
            end
            else
            begin
                want_item = pending_edges.pop_front();
                check_field("edge_res", 12'(want_item.mag), 12'(edge_res));
                check_field("vertical_part", 12'(want_item.vert), 12'(vertical_part));
                check_field("horizontal_part", 12'(want_item.horiz), 12'(horizontal_part));
                check_field("out_row", 12'(want_item.row), 12'(out_row));
                check_field("out_col", 12'(want_item.col), 12'(out_col));
                check_field("frame_last", 12'(want_item.last), 12'(frame_last));
            end
        end
    end

    function automatic bit [pew_pkg::PIX_W-1:0] rand_pixel(int mode, int base);
        int v;
        case (mode)
            MODE_NOISE:    v = $urandom_range(pew_pkg::PIX_MAX);
            MODE_EXTREMES: v = $urandom_range(1) ? pew_pkg::PIX_MAX : 0;
            default:       v = base + $urandom_range(20) - 10;
        endcase
        if (v < 0)
            v = 0;
        if (v > pew_pkg::PIX_MAX)
            v = pew_pkg::PIX_MAX;
        return v[pew_pkg::PIX_W-1:0];
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_pixel(input bit [pew_pkg::PIX_W-1:0] value);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        pixel    <= value;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
        predict_edge(value);
        pixels_sent++;
    endtask

    task automatic send_run(input int count, input int mode);
        int base;
        base = $urandom_range(pew_pkg::PIX_MAX);
        for (int i = 0; i < count; i++)
            send_pixel(rand_pixel(mode, base));
    endtask

    // border items give no output, so allow the pipe to empty as well
    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_edges.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [pew_pkg::CFG_IDX_W-1:0] idx,
                             input logic [pew_pkg::CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == pew_pkg::REG_FRAME_WIDTH || idx == pew_pkg::REG_FRAME_HEIGHT)
        begin
            if (idx == pew_pkg::REG_FRAME_WIDTH)
                width_reg = data[pew_pkg::FW_W-1:0];
            else
                height_reg = data[pew_pkg::FH_W-1:0];
            col_pos = 0;
            row_pos = 0;
        end
        @(negedge clk);
    endtask

    // default geometry after reset: a short run stays in the border rows
    task automatic test_reset_geometry();
        idle_pct  = 27;
        stall_pct = 27;
        send_run(24, MODE_NOISE);
        drain_results();
    endtask

    // 3x3 frames from undersized register values; both parts saturate
    task automatic test_saturation();
        idle_pct  = 0;
        stall_pct = 0;
        write_reg(pew_pkg::REG_FRAME_WIDTH, pew_pkg::CFG_W'(0));
        write_reg(pew_pkg::REG_FRAME_HEIGHT, pew_pkg::CFG_W'(2));
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                send_pixel((r == 0) ? 8'd0 : ((r == 1) ? 8'd7 : 8'd255));
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                send_pixel((c == 0) ? 8'd0 : ((c == 1) ? 8'd100 : 8'd255));
        send_run(9, MODE_NOISE);
        drain_results();
    endtask

    // writes mid-frame: real registers restart, spare slots leave the frame alone
    task automatic test_restart();
        idle_pct  = 27;
        stall_pct = 27;
        write_reg(pew_pkg::REG_FRAME_WIDTH, pew_pkg::CFG_W'(5));
        write_reg(pew_pkg::REG_FRAME_HEIGHT, pew_pkg::CFG_W'(4));
        send_run(7, MODE_NOISE);
        drain_results();
        write_reg(REG_SPARE_A, pew_pkg::CFG_W'($urandom));
        send_run(13, MODE_NOISE);
        send_run(8, MODE_EXTREMES);
        drain_results();
        write_reg(REG_SPARE_B, pew_pkg::CFG_W'($urandom));
        write_reg(pew_pkg::REG_FRAME_HEIGHT, pew_pkg::CFG_W'(4));
        send_run(20, MODE_EXTREMES);
        send_run(6, MODE_NOISE);
        drain_results();
        write_reg(pew_pkg::REG_FRAME_WIDTH, pew_pkg::CFG_W'(3));
        send_run(12, MODE_SMOOTH);
        drain_results();
    endtask

    // oversized width clamps to the line store depth; a short run stays in row 0
    task automatic test_width_limit();
        idle_pct  = 27;
        stall_pct = 27;
        write_reg(pew_pkg::REG_FRAME_WIDTH, pew_pkg::CFG_W'(12'h7FF));
        write_reg(pew_pkg::REG_FRAME_HEIGHT, pew_pkg::CFG_W'(pew_pkg::MIN_DIM));
        send_run(40, MODE_NOISE);
        drain_results();
    endtask

    // tallest frame, narrowest width: the first rows of it
    task automatic test_height_limit();
        idle_pct  = 0;
        stall_pct = 27;
        write_reg(pew_pkg::REG_FRAME_WIDTH, pew_pkg::CFG_W'(1));
        write_reg(pew_pkg::REG_FRAME_HEIGHT, pew_pkg::CFG_W'(12'hFFF));
        send_run(pew_pkg::MIN_DIM * 10, MODE_NOISE);
        drain_results();
    endtask

    task automatic test_random_phase(input int idle, input int stall, input int quota);
        int start;
        int w_data;
        int h_data;
        int total;
        int remaining;
        int pause_at;
        int mode;
        int base;
        idle_pct  = idle;
        stall_pct = stall;
        start     = pixels_sent;
        while (pixels_sent - start < quota)
        begin
            drain_results();
            if ($urandom_range(5) != 0)
            begin
                case ($urandom_range(9))
                    0:       w_data = $urandom_range(2);
                    1:       w_data = 12'h800 | $urandom_range(3, 12);
                    default: w_data = $urandom_range(3, 12);
                endcase
                h_data = ($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(3, 9);
                if ($urandom_range(1))
                begin
                    write_reg(pew_pkg::REG_FRAME_WIDTH, pew_pkg::CFG_W'(w_data));
                    write_reg(pew_pkg::REG_FRAME_HEIGHT, pew_pkg::CFG_W'(h_data));
                end
                else
                begin
                    write_reg(pew_pkg::REG_FRAME_HEIGHT, pew_pkg::CFG_W'(h_data));
                    write_reg(pew_pkg::REG_FRAME_WIDTH, pew_pkg::CFG_W'(w_data));
                end
            end
            total = $urandom_range(1, 3) * active_width() * active_height();
            // now and then a frame cut short
            if ($urandom_range(4) == 0)
                total = $urandom_range(1, total - 1);
            remaining = quota - (pixels_sent - start);
            if (total > remaining)
                total = remaining;
            pause_at = ($urandom_range(3) == 0) ? $urandom_range(1, total - 1) : -1;
            mode     = $urandom_range(MODE_SMOOTH);
            base     = $urandom_range(pew_pkg::PIX_MAX);
            for (int i = 0; i < total; i++)
            begin
                if (i == pause_at)
                    drain_results();
                send_pixel(rand_pixel(mode, base));
            end
        end
        drain_results();
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_reset_geometry();
        test_saturation();
        test_restart();
        test_width_limit();
        test_height_limit();
        test_random_phase(0, 0, PHASE_QUOTA);
        test_random_phase(55, 0, PHASE_QUOTA);
        test_random_phase(0, 55, PHASE_QUOTA);
        test_random_phase(27, 27, PHASE_QUOTA);
        if (errors == 0)
            $display("prewitt_edge_magnitude_top: match");
        else
            $display("prewitt_edge_magnitude_top: mismatch");
        $finish;
    end

endmodule
